@@ hdl/acp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acp_pkg: shared types, codes and helpers of the altitude cascade pid
// micro-op codes, jump conditions, register indexes, control/status structs
// and the q16.16 saturation helpers
// ----------------------------------------------------------------------------
package acp_pkg;

	localparam int PC_W      = 5;
	localparam int OP_W      = 5;
	localparam int JC_W      = 3;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_W     = 48;   // derivative dividend magnitude, |dv| << 16
	localparam int CNT_W     = 6;
	localparam int SUM_W     = 34;   // exact sum of four 32 bit terms

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALT_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIMB    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_P    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_I    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_D    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOVER    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING  = 3'd6;

	// register reset values
	localparam logic signed [31:0] ALT_GAIN_RST = 32'sd65536;
	localparam logic        [30:0] CLIMB_RST    = 31'd131072;
	localparam logic signed [31:0] VEL_GAIN_RST = 32'sd0;
	localparam logic signed [31:0] HOVER_RST    = 32'sd3276800;
	localparam logic signed [31:0] CEILING_RST  = 32'sd5898240;

	// fixed limits, q16.16
	localparam logic signed [31:0] INTEG_LIM = 32'sd983040;   // 15.0
	localparam logic signed [31:0] THR_FLOOR = 32'sd655360;   // 10.0

	// micro-ops
	localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
	localparam logic [OP_W-1:0] OP_AERR     = 5'd1;
	localparam logic [OP_W-1:0] OP_MUL_AG   = 5'd2;
	localparam logic [OP_W-1:0] OP_VTGT     = 5'd3;
	localparam logic [OP_W-1:0] OP_VERR     = 5'd4;
	localparam logic [OP_W-1:0] OP_MUL_PG   = 5'd5;
	localparam logic [OP_W-1:0] OP_P        = 5'd6;
	localparam logic [OP_W-1:0] OP_MUL_DT   = 5'd7;
	localparam logic [OP_W-1:0] OP_INTEG    = 5'd8;
	localparam logic [OP_W-1:0] OP_MUL_IG   = 5'd9;
	localparam logic [OP_W-1:0] OP_I        = 5'd10;
	localparam logic [OP_W-1:0] OP_DIV_INIT = 5'd11;
	localparam logic [OP_W-1:0] OP_DIV_STEP = 5'd12;
	localparam logic [OP_W-1:0] OP_DQ       = 5'd13;
	localparam logic [OP_W-1:0] OP_MUL_DG   = 5'd14;
	localparam logic [OP_W-1:0] OP_D        = 5'd15;
	localparam logic [OP_W-1:0] OP_OUT      = 5'd16;
	localparam logic [OP_W-1:0] OP_HOVER    = 5'd17;

	// jump conditions: taken means pc <= target, else pc <= pc + 1
	localparam logic [JC_W-1:0] JC_NEXT     = 3'd0;
	localparam logic [JC_W-1:0] JC_ALWAYS   = 3'd1;
	localparam logic [JC_W-1:0] JC_NO_IN    = 3'd2;
	localparam logic [JC_W-1:0] JC_DT_ZERO  = 3'd3;
	localparam logic [JC_W-1:0] JC_DIV_MORE = 3'd4;
	localparam logic [JC_W-1:0] JC_OUT_BUSY = 3'd5;

	typedef struct packed {
		logic            in_ready;
		logic [OP_W-1:0] op;
		logic [JC_W-1:0] cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic in_fire;
		logic dt_zero;
		logic div_more;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		logic signed [31:0] alt_gain;
		logic        [30:0] climb;
		logic signed [31:0] vel_p;
		logic signed [31:0] vel_i;
		logic signed [31:0] vel_d;
		logic signed [31:0] hover;
		logic signed [31:0] ceiling;
	} cfg_regs_t;

	// q16.16 product: floor shift by 16, saturate to 32 bits
	function automatic logic signed [31:0] sat_q(input logic signed [63:0] p);
		logic signed [47:0] s;
		s = p[63:16];
		if (s > 48'sd2147483647)
			return 32'sh7fff_ffff;
		else if (s < -48'sd2147483648)
			return 32'sh8000_0000;
		else
			return s[31:0];
	endfunction

	// saturate a wide sum to 32 bits
	function automatic logic signed [31:0] sat_sum(input logic signed [SUM_W-1:0] v);
		if (v > 34'sd2147483647)
			return 32'sh7fff_ffff;
		else if (v < -34'sd2147483648)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

@@ hdl/acp_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acp channel interfaces
// sample beats in, throttle beats out, register writes
// ----------------------------------------------------------------------------
interface acp_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] target_altitude;
	logic signed [31:0] measured_altitude;
	logic signed [31:0] measured_velocity;
	logic        [30:0] time_step;

	modport source(output valid, target_altitude, measured_altitude, measured_velocity,
		time_step, input ready);
	modport sink(input valid, target_altitude, measured_altitude, measured_velocity,
		time_step, output ready);
endinterface

interface acp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] throttle;

	modport source(output valid, throttle, input ready);
	modport sink(input valid, throttle, output ready);
endinterface

interface acp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [acp_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/acp_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acp_seq: microcode sequencer
// step counter over a read-only program, one control word per step
// ----------------------------------------------------------------------------
module acp_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  acp_pkg::stat_t stat,
	output acp_pkg::ctl_t  ctl
);

	localparam logic [acp_pkg::PC_W-1:0] U_IDLE  = 5'd0;
	localparam logic [acp_pkg::PC_W-1:0] U_DIV   = 5'd12;
	localparam logic [acp_pkg::PC_W-1:0] U_OUT   = 5'd16;
	localparam logic [acp_pkg::PC_W-1:0] U_HOVER = 5'd18;

	logic [acp_pkg::PC_W-1:0] pc_q;
	logic                     taken;

	function automatic acp_pkg::ctl_t ucode(input logic [acp_pkg::PC_W-1:0] pc);
		acp_pkg::ctl_t w;
		w = '{in_ready: 1'b0, op: acp_pkg::OP_NOP, cond: acp_pkg::JC_NEXT, target: U_IDLE};
		case (pc)
			5'd0: begin
				w.in_ready = 1'b1;
				w.cond     = acp_pkg::JC_NO_IN;
				w.target   = U_IDLE;
			end
			5'd1: begin
				w.op     = acp_pkg::OP_AERR;
				w.cond   = acp_pkg::JC_DT_ZERO;
				w.target = U_HOVER;
			end
			5'd2:  w.op = acp_pkg::OP_MUL_AG;
			5'd3:  w.op = acp_pkg::OP_VTGT;
			5'd4:  w.op = acp_pkg::OP_VERR;
			5'd5:  w.op = acp_pkg::OP_MUL_PG;
			5'd6:  w.op = acp_pkg::OP_P;
			5'd7:  w.op = acp_pkg::OP_MUL_DT;
			5'd8:  w.op = acp_pkg::OP_INTEG;
			5'd9:  w.op = acp_pkg::OP_MUL_IG;
			5'd10: w.op = acp_pkg::OP_I;
			5'd11: w.op = acp_pkg::OP_DIV_INIT;
			5'd12: begin
				w.op     = acp_pkg::OP_DIV_STEP;
				w.cond   = acp_pkg::JC_DIV_MORE;
				w.target = U_DIV;
			end
			5'd13: w.op = acp_pkg::OP_DQ;
			5'd14: w.op = acp_pkg::OP_MUL_DG;
			5'd15: w.op = acp_pkg::OP_D;
			5'd16: begin
				w.op     = acp_pkg::OP_OUT;
				w.cond   = acp_pkg::JC_OUT_BUSY;
				w.target = U_OUT;
			end
			5'd18: begin
				w.op     = acp_pkg::OP_HOVER;
				w.cond   = acp_pkg::JC_OUT_BUSY;
				w.target = U_HOVER;
			end
			default: w.cond = acp_pkg::JC_ALWAYS;   // 17, 19 and unused steps
		endcase
		return w;
	endfunction

	assign ctl = ucode(pc_q);

	always_comb begin
		case (ctl.cond)
			acp_pkg::JC_NEXT:     taken = 1'b0;
			acp_pkg::JC_ALWAYS:   taken = 1'b1;
			acp_pkg::JC_NO_IN:    taken = ~stat.in_fire;
			acp_pkg::JC_DT_ZERO:  taken = stat.dt_zero;
			acp_pkg::JC_DIV_MORE: taken = stat.div_more;
			acp_pkg::JC_OUT_BUSY: taken = stat.out_busy;
			default:              taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= U_IDLE;
		end else if (taken) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

@@ hdl/acp_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acp_dpath: controller datapath
// shared multiplier, restoring divider, accumulator and result register
// ----------------------------------------------------------------------------
module acp_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  acp_pkg::ctl_t      ctl,
	input  acp_pkg::cfg_regs_t regs,
	output acp_pkg::stat_t     stat,
	acp_in_if.sink             sample,
	acp_out_if.source          cmd
);

	// captured sample
	logic signed [31:0] tgt_q, alt_q, vel_q;
	logic        [30:0] dt_q;
	// work registers
	logic signed [31:0]               x_q;
	logic signed [31:0]               verr_q;
	logic signed [acp_pkg::SUM_W-1:0] sum_q;
	logic signed [63:0]               prod_q;
	logic        [30:0]               rem_q;
	logic        [acp_pkg::NUM_W-1:0] quo_q;
	logic                             neg_q;
	logic        [acp_pkg::CNT_W-1:0] cnt_q;
	logic signed [31:0]               res_q;
	// loop state
	logic signed [31:0] integ_q, prev_q;
	logic               res_vld_q;

	logic                             in_fire, out_busy, load_res;
	logic signed [31:0]               mul_a, mul_b;
	logic signed [63:0]               prod;
	logic signed [31:0]               q_sat;
	logic signed [31:0]               lim, vtgt;
	logic signed [acp_pkg::SUM_W-1:0] aerr_w, verr_w, dv_w;
	logic signed [48:0]               integ_w;
	logic signed [31:0]               integ_nx;
	logic        [31:0]               dv_mag;
	logic        [32:0]               trial;
	logic        [31:0]               shifted;
	logic signed [31:0]               dq;
	logic signed [31:0]               thr;

	assign sample.ready = ctl.in_ready;
	assign in_fire      = sample.valid & sample.ready;
	assign out_busy     = res_vld_q & ~cmd.ready;
	assign load_res     = ((ctl.op == acp_pkg::OP_OUT) || (ctl.op == acp_pkg::OP_HOVER))
		&& !out_busy;

	assign stat.in_fire  = in_fire;
	assign stat.dt_zero  = (dt_q == '0);
	assign stat.div_more = (cnt_q != '0);
	assign stat.out_busy = out_busy;

	assign cmd.valid    = res_vld_q;
	assign cmd.throttle = res_q;

	// shared multiplier operand select
	always_comb begin
		case (ctl.op)
			acp_pkg::OP_MUL_AG: begin mul_a = regs.alt_gain; mul_b = x_q;             end
			acp_pkg::OP_MUL_PG: begin mul_a = regs.vel_p;    mul_b = verr_q;          end
			acp_pkg::OP_MUL_DT: begin mul_a = verr_q;        mul_b = {1'b0, dt_q};    end
			acp_pkg::OP_MUL_IG: begin mul_a = regs.vel_i;    mul_b = integ_q;         end
			acp_pkg::OP_MUL_DG: begin mul_a = regs.vel_d;    mul_b = x_q;             end
			default:            begin mul_a = '0;            mul_b = '0;              end
		endcase
	end
	assign prod  = mul_a * mul_b;
	assign q_sat = acp_pkg::sat_q(prod_q);

	// outer loop and error terms
	assign aerr_w = {{2{tgt_q[31]}}, tgt_q} - {{2{alt_q[31]}}, alt_q};
	assign verr_w = {{2{x_q[31]}}, x_q} - {{2{vel_q[31]}}, vel_q};
	assign dv_w   = {{2{verr_q[31]}}, verr_q} - {{2{prev_q[31]}}, prev_q};
	assign lim    = {1'b0, regs.climb};

	always_comb begin
		vtgt = q_sat;
		if (vtgt > lim)
			vtgt = lim;
		if (vtgt < -lim)
			vtgt = -lim;
	end

	// integral accumulate with +-15 clamp
	assign integ_w = {{17{integ_q[31]}}, integ_q} + {prod_q[63], prod_q[63:16]};
	always_comb begin
		if (integ_w > $signed({{17{acp_pkg::INTEG_LIM[31]}}, acp_pkg::INTEG_LIM}))
			integ_nx = acp_pkg::INTEG_LIM;
		else if (integ_w < -$signed({{17{acp_pkg::INTEG_LIM[31]}}, acp_pkg::INTEG_LIM}))
			integ_nx = -acp_pkg::INTEG_LIM;
		else
			integ_nx = integ_w[31:0];
	end

	// divider: magnitude of the error change, one quotient bit per step
	assign dv_mag  = dv_w[acp_pkg::SUM_W-1] ? 32'(-dv_w) : dv_w[31:0];
	assign shifted = {rem_q, quo_q[acp_pkg::NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dt_q};

	// signed quotient, truncated toward zero and saturated
	always_comb begin
		if (!neg_q)
			dq = (quo_q > 48'd2147483647) ? 32'sh7fff_ffff : quo_q[31:0];
		else
			dq = (quo_q > 48'd2147483648) ? 32'sh8000_0000 : -quo_q[31:0];
	end

	// throttle clamp: ceiling first, floor last
	always_comb begin
		thr = acp_pkg::sat_sum(sum_q);
		if (thr > regs.ceiling)
			thr = regs.ceiling;
		if (thr < acp_pkg::THR_FLOOR)
			thr = acp_pkg::THR_FLOOR;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			tgt_q <= sample.target_altitude;
			alt_q <= sample.measured_altitude;
			vel_q <= sample.measured_velocity;
			dt_q  <= sample.time_step;
		end
		case (ctl.op)
			acp_pkg::OP_AERR:   x_q    <= acp_pkg::sat_sum(aerr_w);
			acp_pkg::OP_VTGT:   x_q    <= vtgt;
			acp_pkg::OP_VERR:   verr_q <= acp_pkg::sat_sum(verr_w);
			acp_pkg::OP_P:      sum_q  <= {{2{regs.hover[31]}}, regs.hover}
				+ {{2{q_sat[31]}}, q_sat};
			acp_pkg::OP_I,
			acp_pkg::OP_D:      sum_q  <= sum_q + {{2{q_sat[31]}}, q_sat};
			acp_pkg::OP_DIV_INIT: begin
				quo_q <= {dv_mag, 16'h0000};
				rem_q <= '0;
				neg_q <= dv_w[acp_pkg::SUM_W-1];
				cnt_q <= acp_pkg::CNT_W'(acp_pkg::NUM_W - 1);
			end
			acp_pkg::OP_DIV_STEP: begin
				rem_q <= trial[32] ? shifted[30:0] : trial[30:0];
				quo_q <= {quo_q[acp_pkg::NUM_W-2:0], ~trial[32]};
				cnt_q <= cnt_q - 1'b1;
			end
			acp_pkg::OP_DQ:     x_q    <= dq;
			default: ;
		endcase
		case (ctl.op)
			acp_pkg::OP_MUL_AG,
			acp_pkg::OP_MUL_PG,
			acp_pkg::OP_MUL_DT,
			acp_pkg::OP_MUL_IG,
			acp_pkg::OP_MUL_DG: prod_q <= prod;
			default: ;
		endcase
		if (load_res)
			res_q <= (ctl.op == acp_pkg::OP_HOVER) ? regs.hover : thr;
	end

	// loop state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q   <= '0;
			prev_q    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (ctl.op == acp_pkg::OP_INTEG)
				integ_q <= integ_nx;
			if (ctl.op == acp_pkg::OP_DIV_INIT)
				prev_q <= verr_q;
			if (load_res)
				res_vld_q <= 1'b1;
			else if (cmd.valid && cmd.ready)
				res_vld_q <= 1'b0;
		end
	end

endmodule

@@ hdl/altitude_cascade_pid_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_cascade_pid_core: two-loop altitude controller, q16.16
// proportional altitude loop feeding a clamped velocity pid, one throttle
// beat per sample beat, run by a microcoded sequencer over a shared datapath
// ----------------------------------------------------------------------------
//
//  channel  dir  beat carries                                          ready
//  -------  ---  ----------------------------------------------------  -----------------
//  sample   in   target/measured altitude, measured velocity, time_step  sequencer idle
//  cmd      out  throttle                                              held until taken
//  cfg      in   index, data (register write)                          always
//
// work per sample: the 48 one-bit steps of the restoring divider for the
//   derivative set most of it, the rest is one micro-op per cycle around the
//   single 32x32 multiplier while no waiting throttle holds the result step
// zero time_step: the program skips straight to the hover result step
// reset: clears the step counter, integral, previous error and result valid;
//   registers return to their defaults
// stalls: a waiting throttle holds the next result step only; the next sample
//   is taken while the previous throttle is still waiting
//
module altitude_cascade_pid_core (
	input logic       clk,
	input logic       arst_n,
	acp_cfg_if.sink   cfg,
	acp_in_if.sink    sample,
	acp_out_if.source cmd
);

	acp_pkg::cfg_regs_t regs_q;   // configuration registers
	acp_pkg::ctl_t      ctl;      // current control word
	acp_pkg::stat_t     stat;     // datapath flags for jumps

	// register writes must be issued only while the controller is idle; the core itself does not enforce it
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.alt_gain <= acp_pkg::ALT_GAIN_RST;
			regs_q.climb    <= acp_pkg::CLIMB_RST;
			regs_q.vel_p    <= acp_pkg::VEL_GAIN_RST;
			regs_q.vel_i    <= acp_pkg::VEL_GAIN_RST;
			regs_q.vel_d    <= acp_pkg::VEL_GAIN_RST;
			regs_q.hover    <= acp_pkg::HOVER_RST;
			regs_q.ceiling  <= acp_pkg::CEILING_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				acp_pkg::CFG_ALT_GAIN: regs_q.alt_gain <= cfg.data;
				acp_pkg::CFG_CLIMB:    regs_q.climb    <= cfg.data[30:0];
				acp_pkg::CFG_VEL_P:    regs_q.vel_p    <= cfg.data;
				acp_pkg::CFG_VEL_I:    regs_q.vel_i    <= cfg.data;
				acp_pkg::CFG_VEL_D:    regs_q.vel_d    <= cfg.data;
				acp_pkg::CFG_HOVER:    regs_q.hover    <= cfg.data;
				acp_pkg::CFG_CEILING:  regs_q.ceiling  <= cfg.data;
				default: ;   // unknown index, write dropped
			endcase
		end
	end

	// program counter and control store
	acp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// arithmetic, loop state and the throttle output register
	acp_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.regs   (regs_q),
		.stat   (stat),
		.sample (sample),
		.cmd    (cmd)
	);

	// one sample in flight: the sequencer leaves idle right after an accept
	ap_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("sample accepted while another is in work");

	// zero time_step must branch to hover and never reach the divider
	ap_div_dt: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == acp_pkg::OP_DIV_STEP |-> !stat.dt_zero)
		else $error("divider running with zero divisor");

	// a throttle beat appears only from a result step of the program
	ap_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cmd.valid) |-> $past(ctl.op == acp_pkg::OP_OUT || ctl.op == acp_pkg::OP_HOVER))
		else $error("throttle valid raised outside a result step");

endmodule

@@ tb/sv/altitude_throttle_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_throttle_checker: throttle prediction and compare
// watches the register, sample and throttle channels of the altitude cascade
// pid, computes each throttle beat from its own copy of the registers and loop
// state, and compares every accepted throttle beat with the oldest one owed
// ----------------------------------------------------------------------------
module altitude_throttle_checker (
	input logic clk,
	input logic arst_n,
	acp_cfg_if  cfg,
	acp_in_if   sample,
	acp_out_if  cmd,
	output int  owed,
	output int  mismatches
);
	import acp_pkg::*;

	cfg_regs_t          regs;
	logic signed [31:0] integ_acc;
	logic signed [31:0] last_verr;
	logic signed [31:0] throttle_due[$];
	logic signed [31:0] want;
	int                 errs;

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fff_ffff;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return 32'(v);
	endfunction

	// q16.16 product, floor on the shift, saturated
	function automatic logic signed [31:0] fix_mul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		longint prod;
		prod = longint'(a) * longint'(b);
		return clip32(prod >>> 16);
	endfunction

	// one control step; unless time_step is zero, updates integral and previous error
	function automatic logic signed [31:0] next_throttle(input logic signed [31:0] tgt,
		input logic signed [31:0] alt, input logic signed [31:0] vel, input logic [30:0] dt);
		longint             step;
		longint             lim;
		longint             sum;
		longint             dq;
		logic signed [31:0] aerr;
		logic signed [31:0] vtgt;
		logic signed [31:0] verr;
		logic signed [31:0] p_t;
		logic signed [31:0] i_t;
		logic signed [31:0] d_t;
		if (dt == '0)
			return regs.hover;
		step = {33'd0, dt};
		aerr = clip32(longint'(tgt) - longint'(alt));
		vtgt = fix_mul(regs.alt_gain, aerr);
		lim = {33'd0, regs.climb};
		if (longint'(vtgt) > lim)
			vtgt = 32'(lim);
		else if (longint'(vtgt) < -lim)
			vtgt = 32'(-lim);
		verr = clip32(longint'(vtgt) - longint'(vel));
		p_t = fix_mul(regs.vel_p, verr);

		sum = longint'(integ_acc) + ((longint'(verr) * step) >>> 16);
		if (sum > longint'(INTEG_LIM))
			sum = longint'(INTEG_LIM);
		else if (sum < -longint'(INTEG_LIM))
			sum = -longint'(INTEG_LIM);
		integ_acc = 32'(sum);
		i_t = fix_mul(regs.vel_i, integ_acc);

		dq = ((longint'(verr) - longint'(last_verr)) * 64'sd65536) / step;
		d_t = fix_mul(regs.vel_d, clip32(dq));
		last_verr = verr;

		sum = longint'(regs.hover) + longint'(p_t) + longint'(i_t) + longint'(d_t);
		sum = longint'(clip32(sum));
		if (sum > longint'(regs.ceiling))
			sum = longint'(regs.ceiling);
		if (sum < longint'(THR_FLOOR))
			sum = longint'(THR_FLOOR);
		return 32'(sum);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.alt_gain = ALT_GAIN_RST;
			regs.climb    = CLIMB_RST;
			regs.vel_p    = VEL_GAIN_RST;
			regs.vel_i    = VEL_GAIN_RST;
			regs.vel_d    = VEL_GAIN_RST;
			regs.hover    = HOVER_RST;
			regs.ceiling  = CEILING_RST;
			integ_acc = '0;
			last_verr = '0;
			throttle_due.delete();
			errs = 0;
			owed <= 0;
			mismatches <= 0;
		end else begin
			// older beats first: a throttle taken now belongs to an earlier sample
			if (cmd.valid && cmd.ready) begin
				if (throttle_due.size() == 0) begin
					errs++;
					$error("throttle: expected none, actual %0d", cmd.throttle);
				end else begin
					want = throttle_due.pop_front();
					if (cmd.throttle !== want) begin
						errs++;
						$error("throttle: expected %0d, actual %0d", want, cmd.throttle);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ALT_GAIN: regs.alt_gain = cfg.data;
					CFG_CLIMB:    regs.climb    = cfg.data[30:0];
					CFG_VEL_P:    regs.vel_p    = cfg.data;
					CFG_VEL_I:    regs.vel_i    = cfg.data;
					CFG_VEL_D:    regs.vel_d    = cfg.data;
					CFG_HOVER:    regs.hover    = cfg.data;
					CFG_CEILING:  regs.ceiling  = cfg.data;
					default: ;
				endcase
			end
			if (sample.valid && sample.ready)
				throttle_due.push_back(next_throttle(sample.target_altitude,
					sample.measured_altitude, sample.measured_velocity, sample.time_step));
			owed <= throttle_due.size();
			mismatches <= errs;
		end
	end

endmodule

@@ tb/sv/tb_altitude_cascade_pid_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_altitude_cascade_pid_core: stimulus and verdict for the altitude pid
// drives register writes and sample beats with random gaps, stalls the
// throttle channel at random, and leaves prediction and compare to the
// throttle checker that sits beside the core
// ----------------------------------------------------------------------------
module tb_altitude_cascade_pid_core;
	import acp_pkg::*;

	localparam int          Q            = 65536;         // 1.0 in q16.16
	localparam int          PHASES       = 6;
	localparam int          PHASE_ITEMS  = 75;
	localparam int          DRAIN_CYCLES = 80;            // idle time at the end, watching for stray beats
	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
	// index with no register behind it, the write must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic        clk;
	logic        arst_n;
	int unsigned cycles = 0;
	int          owed;
	int          mismatches;
	int          send_calm = 0;   // beats left in a no-gap stretch, sample side
	int          take_calm = 0;   // beats left in a no-stall stretch, throttle side

	acp_cfg_if cfg_ch();
	acp_in_if  sample_ch();
	acp_out_if cmd_ch();

	altitude_cascade_pid_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (sample_ch),
		.cmd    (cmd_ch)
	);

	altitude_throttle_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_ch),
		.sample     (sample_ch),
		.cmd        (cmd_ch),
		.owed       (owed),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop if the core hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_altitude_cascade_pid_core: done, errors");
			$finish;
		end
	end

	// gap before a beat: random, with runs of back-to-back beats mixed in
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	// register value: mostly inside a sane window, extremes when wild
	function automatic logic [31:0] pick_setting(input logic signed [31:0] lo,
		input logic signed [31:0] hi, input bit wild);
		int unsigned roll;
		roll = $urandom_range(0, 7);
		if (wild && roll == 0)
			return S_MAX;
		if (wild && roll == 1)
			return S_MIN;
		if (wild && roll == 2)
			return $urandom();
		return lo + $urandom_range(0, 32'(hi - lo));
	endfunction

	// corner-heavy word for broken samples
	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return S_MAX;
			2: return S_MIN;
			3: return 32'hffff_ffff;
			4: return 32'd1;
			default: return $urandom();
		endcase
	endfunction

	// throttle side: stall a random number of cycles, then take one beat
	initial begin
		int stall;
		cmd_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_wait(take_calm);
			if (stall > 0) begin
				cmd_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			cmd_ch.ready = 1'b1;
			do @(posedge clk); while (!cmd_ch.valid);
			@(negedge clk);
		end
	end

	// one sample beat; valid stays up afterwards so back-to-back beats need no dip
	task automatic push_sample(input logic signed [31:0] tgt, input logic signed [31:0] alt,
		input logic signed [31:0] vel, input logic [30:0] dt);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.target_altitude   = tgt;
		sample_ch.measured_altitude = alt;
		sample_ch.measured_velocity = vel;
		sample_ch.time_step         = dt;
		sample_ch.valid             = 1'b1;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	// hold samples back until every throttle beat owed has been taken
	task automatic settle();
		sample_ch.valid = 1'b0;
		wait (owed == 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_ch.index = idx;
		cfg_ch.data  = value;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// full register set, written only with the core idle
	task automatic apply_settings(input logic [31:0] ag, input logic [31:0] climb,
		input logic [31:0] vp, input logic [31:0] vi, input logic [31:0] vd,
		input logic [31:0] hv, input logic [31:0] ceil);
		settle();
		write_reg(CFG_ALT_GAIN, ag);
		write_reg(CFG_CLIMB, climb);
		write_reg(CFG_VEL_P, vp);
		write_reg(CFG_VEL_I, vi);
		write_reg(CFG_VEL_D, vd);
		write_reg(CFG_HOVER, hv);
		write_reg(CFG_CEILING, ceil);
		cfg_ch.valid = 1'b0;
	endtask

	initial begin
		int          roll;
		int          tgt;
		int          off;
		int          vel;
		logic [30:0] dt;
		bit          wild;

		// everything known from time zero, reset held, then released on a falling edge
		arst_n                      = 1'b0;
		cfg_ch.valid                = 1'b0;
		cfg_ch.index                = '0;
		cfg_ch.data                 = '0;
		sample_ch.valid             = 1'b0;
		sample_ch.target_altitude   = '0;
		sample_ch.measured_altitude = '0;
		sample_ch.measured_velocity = '0;
		sample_ch.time_step         = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// register defaults: zero pid gains, so hover throttle inside the clamps
		push_sample(10 * Q, 0, 0, 31'(Q / 100));
		push_sample(0, 0, 0, 31'd0);

		// moderate gains, climb limit 2 m/s
		apply_settings(Q, 2 * Q, 2 * Q, Q / 2, Q / 4, 50 * Q, 90 * Q);
		push_sample(10 * Q, 5 * Q, 0, 31'd655);
		// zero time step: hover back, loop state must not move
		push_sample(0, 0, 0, 31'd0);
		// altitude error and velocity error saturate
		push_sample(S_MAX, S_MIN, S_MIN, 31'd1);
		push_sample(S_MIN, S_MAX, S_MAX, 31'h7fff_ffff);
		// long climb demand pins the integral at +15, then a descent pins it at -15
		repeat (4) push_sample(100 * Q, 0, -5 * Q, 31'(2 * Q));
		repeat (3) push_sample(-100 * Q, 0, 5 * Q, 31'(2 * Q));
		// all ones, then the smallest time step with a huge derivative
		push_sample(-1, -1, -1, 31'h7fff_ffff);
		push_sample(0, 0, 0, 31'd1);

		// extreme gains, hover at the bottom, ceiling under the floor so the floor wins
		apply_settings(S_MAX, 32'h7fff_ffff, S_MIN, S_MAX, S_MIN, S_MIN, 5 * Q);
		push_sample(S_MAX, S_MIN, 0, 31'(Q));
		push_sample(3 * Q, 0, Q, 31'd1);
		push_sample(0, 0, 0, 31'd0);

		// a write to the unused index goes nowhere; opposite extremes, climb limit zero
		settle();
		write_reg(CFG_UNUSED, $urandom());
		apply_settings(S_MIN, 32'd0, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX);
		push_sample(5 * Q, 0, 3 * Q, 31'(Q / 2));
		push_sample(-5 * Q, 2 * Q, -3 * Q, 31'd100);
		push_sample(S_MIN, S_MAX, S_MIN, 31'd1);
		push_sample(0, 0, 0, 31'd0);

		// random phases: first two with sane registers only, later ones with extremes
		for (int ph = 0; ph < PHASES; ph++) begin
			wild = (ph >= 2);
			apply_settings(pick_setting(-4 * Q, 4 * Q, wild), pick_setting(0, 10 * Q, wild),
				pick_setting(-4 * Q, 4 * Q, wild), pick_setting(-4 * Q, 4 * Q, wild),
				pick_setting(-4 * Q, 4 * Q, wild), pick_setting(30 * Q, 70 * Q, wild),
				pick_setting(60 * Q, 100 * Q, wild));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// now and then drain the core fully before the next sample
				if (k == 10 || $urandom_range(0, 39) == 0)
					settle();
				roll = $urandom_range(0, 19);
				if (roll == 0) begin
					// raw noise on every field
					push_sample($urandom(), $urandom(), $urandom(), 31'($urandom()));
				end else if (roll == 1) begin
					// skipped step between live ones
					push_sample($urandom(), $urandom(), $urandom(), 31'd0);
				end else if (roll == 2) begin
					push_sample(any_word(), any_word(), any_word(), 31'(any_word()));
				end else begin
					// flight-like sample: altitude near target, modest speed, short step
					tgt = int'($urandom_range(0, 400 * Q)) - 200 * Q;
					off = int'($urandom_range(0, 40 * Q)) - 20 * Q;
					vel = int'($urandom_range(0, 40 * Q)) - 20 * Q;
					if ($urandom_range(0, 7) == 0)
						dt = 31'($urandom_range(1, 4 * Q));
					else
						dt = 31'($urandom_range(1, Q / 10));
					push_sample(tgt, tgt - off, vel, dt);
				end
			end
		end

		// all owed beats taken, then let the core sit a while for strays
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("tb_altitude_cascade_pid_core: done, clean");
		else
			$display("tb_altitude_cascade_pid_core: done, errors");
		$finish;
	end

endmodule
